// ===== rtl/prqs_pkg.sv =====
`default_nettype none

package prqs_pkg;

  localparam int NUM_LEVELS  = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_TASKS   = 64;

  localparam int OP_W     = 2;
  localparam int ID_W     = 6;
  localparam int PRIO_W   = 5;
  localparam int STATUS_W = 2;

  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int CMD_DEPTH = 2;
  localparam int CPTR_W    = $clog2(CMD_DEPTH);
  localparam int CCNT_W    = $clog2(CMD_DEPTH + 1);

  localparam int RES_DEPTH = 2;
  localparam int RPTR_W    = $clog2(RES_DEPTH);
  localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_CONSUME = 2'd1,
    OP_PEEK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_READY = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_REJECT,
    KIND_CONSUME,
    KIND_PEEK,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] prio;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/priority_ready_queue_scheduler.sv =====
// Channel    Direction  Handshake         Word
// request    in         push / full       op_i, task_id_i, task_priority_i
// result     out        empty / pop       status_o, out_task_id_o, out_priority_o
//
// An add, a refused add, an empty consume or peek and an unused op are answered
// from the idle state; a consume or peek that finds a task also passes the read
// state, set by the registered read of the task-id memory. With the back end
// free, a word accepted into the request slots has its result written into the
// result queue as the back end takes it (as it leaves the read state for a hit).
// Reset clears pointers, counts and ready marks at once; no clearing pass.
// The back end stalls while the two-word result queue is full, and full rises
// once two requests wait in front of it.
`default_nettype none

module priority_ready_queue_scheduler (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           push,
  output logic                          full,
  input  wire  [prqs_pkg::OP_W-1:0]     op_i,
  input  wire  [prqs_pkg::ID_W-1:0]     task_id_i,
  input  wire  [prqs_pkg::PRIO_W-1:0]   task_priority_i,
  output logic                          empty,
  input  wire                           pop,
  output logic [prqs_pkg::STATUS_W-1:0] status_o,
  output logic [prqs_pkg::ID_W-1:0]     out_task_id_o,
  output logic [prqs_pkg::PRIO_W-1:0]   out_priority_o
);
  import prqs_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_space;
  logic res_push;
  res_t res;

  prqs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_take_i      (cmd_take)
  );

  prqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  prqs_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_push_i     (res_push),
    .res_i          (res),
    .res_space_o    (res_space),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .out_task_id_o  (out_task_id_o),
    .out_priority_o (out_priority_o)
  );

endmodule

`default_nettype wire

// ===== rtl/prqs_front.sv =====
`default_nettype none

module prqs_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           push,
  output logic                          full,
  input  wire  [prqs_pkg::OP_W-1:0]     op_i,
  input  wire  [prqs_pkg::ID_W-1:0]     task_id_i,
  input  wire  [prqs_pkg::PRIO_W-1:0]   task_priority_i,
  output logic                          cmd_valid_o,
  output prqs_pkg::cmd_t                cmd_o,
  input  wire                           cmd_take_i
);
  import prqs_pkg::*;

  cmd_t              slot_q [CMD_DEPTH];
  logic [CPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CCNT_W-1:0] count_q, count_d;
  cmd_t              in_cmd;
  logic              push_ok;
  logic              take_ok;

  // Adds with a level or task id beyond the tables are marked here so the
  // back end never indexes its state with them.
  always_comb begin
    in_cmd.task_id = task_id_i;
    in_cmd.prio    = task_priority_i;
    case (op_e'(op_i))
      OP_ADD: begin
        if (int'(task_priority_i) >= NUM_LEVELS || int'(task_id_i) >= MAX_TASKS) begin
          in_cmd.kind = KIND_REJECT;
        end else begin
          in_cmd.kind = KIND_ADD;
        end
      end
      OP_CONSUME: in_cmd.kind = KIND_CONSUME;
      OP_PEEK:    in_cmd.kind = KIND_PEEK;
      default:    in_cmd.kind = KIND_NOP;
    endcase
  end

  assign full        = (count_q == CCNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push_ok     = push && !full;
  assign take_ok     = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CPTR_W'(1);
    end
    if (take_ok) begin
      rd_ptr_d = (rd_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CPTR_W'(1);
    end
    if (push_ok && !take_ok) begin
      count_d = count_q + CCNT_W'(1);
    end else if (take_ok && !push_ok) begin
      count_d = count_q - CCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prqs_back.sv =====
`default_nettype none

module prqs_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cmd_valid_i,
  input  prqs_pkg::cmd_t   cmd_i,
  output logic             cmd_take_o,
  input  wire              res_space_i,
  output logic             res_push_o,
  output prqs_pkg::res_t   res_o
);
  import prqs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e             state_q;
  logic [LVL_W-1:0]   lvl_q;
  logic               take_q;

  logic [ID_W-1:0]       store_q [MEM_DEPTH];
  logic [ID_W-1:0]       rdata_q;
  logic [PTR_W-1:0]      heads_q  [NUM_LEVELS];
  logic [PTR_W-1:0]      tails_q  [NUM_LEVELS];
  logic [CNT_W-1:0]      counts_q [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] active_q;
  logic [MAX_TASKS-1:0]  ready_q;

  logic [NUM_LEVELS-1:0] lowest;
  logic [LVL_W-1:0]      first_lvl;
  logic                  any_active;
  logic [LVL_W-1:0]      pr_idx;
  logic [TASK_W-1:0]     id_idx;
  logic [TASK_W-1:0]     rid_idx;
  logic                  add_ready;
  logic                  add_full;
  logic                  go;
  logic                  add_en;
  logic                  read_en;
  logic                  pop_en;
  logic                  clear_en;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    ptr_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Isolate the lowest set bit of the active mask, then turn the one-hot
  // word into a level number with one OR tree per output bit.
  always_comb begin
    lowest    = active_q & (~active_q + NUM_LEVELS'(1));
    first_lvl = '0;
    for (int b = 0; b < LVL_W; b++) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (((l >> b) & 1) == 1) begin
          first_lvl[b] = first_lvl[b] | lowest[l];
        end
      end
    end
  end

  assign any_active = |active_q;
  assign pr_idx     = LVL_W'(cmd_i.prio);
  assign id_idx     = TASK_W'(cmd_i.task_id);
  assign rid_idx    = TASK_W'(rdata_q);
  assign add_ready  = ready_q[id_idx];
  assign add_full   = (counts_q[pr_idx] == CNT_W'(QUEUE_DEPTH));

  assign go         = (state_q == S_IDLE) && cmd_valid_i && res_space_i;
  assign cmd_take_o = go;
  assign add_en     = go && (cmd_i.kind == KIND_ADD) && !add_ready && !add_full;
  assign read_en    = go && (cmd_i.kind == KIND_CONSUME || cmd_i.kind == KIND_PEEK)
                      && any_active;
  assign pop_en     = read_en && (cmd_i.kind == KIND_CONSUME);
  assign clear_en   = (state_q == S_READ) && take_q && (int'(rdata_q) < MAX_TASKS);

  assign waddr = ADDR_W'(pr_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tails_q[pr_idx]);
  assign raddr = ADDR_W'(first_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(heads_q[first_lvl]);

  always_comb begin
    res_push_o   = 1'b0;
    res_o.status = ST_EMPTY;
    res_o.task_id = '0;
    res_o.prio    = '0;
    if (state_q == S_READ) begin
      res_push_o    = 1'b1;
      res_o.status  = ST_OK;
      res_o.task_id = rdata_q;
      res_o.prio    = PRIO_W'(lvl_q);
    end else if (go && !read_en) begin
      res_push_o = 1'b1;
      case (cmd_i.kind)
        KIND_ADD: begin
          if (add_ready) begin
            res_o.status = ST_READY;
          end else if (add_full) begin
            res_o.status = ST_FULL;
          end else begin
            res_o.status = ST_OK;
          end
        end
        KIND_REJECT: res_o.status = ST_FULL;
        default:     res_o.status = ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      take_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (read_en) begin
            state_q <= S_READ;
            lvl_q   <= first_lvl;
            take_q  <= pop_en;
          end
        end
        S_READ: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads_q[l]  <= '0;
        tails_q[l]  <= '0;
        counts_q[l] <= '0;
      end
      active_q <= '0;
      ready_q  <= '0;
    end else begin
      if (add_en) begin
        tails_q[pr_idx]  <= ptr_next(tails_q[pr_idx]);
        counts_q[pr_idx] <= counts_q[pr_idx] + CNT_W'(1);
        active_q[pr_idx] <= 1'b1;
        ready_q[id_idx]  <= 1'b1;
      end
      if (pop_en) begin
        heads_q[first_lvl]  <= ptr_next(heads_q[first_lvl]);
        counts_q[first_lvl] <= counts_q[first_lvl] - CNT_W'(1);
        if (counts_q[first_lvl] == CNT_W'(1)) begin
          active_q[first_lvl] <= 1'b0;
        end
      end
      // The task id is only known once the registered read returns.
      if (clear_en) begin
        ready_q[rid_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_en) begin
      store_q[waddr] <= cmd_i.task_id;
    end
    if (read_en) begin
      rdata_q <= store_q[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prqs_out.sv =====
`default_nettype none

module prqs_out (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           res_push_i,
  input  prqs_pkg::res_t                res_i,
  output logic                          res_space_o,
  output logic                          empty,
  input  wire                           pop,
  output logic [prqs_pkg::STATUS_W-1:0] status_o,
  output logic [prqs_pkg::ID_W-1:0]     out_task_id_o,
  output logic [prqs_pkg::PRIO_W-1:0]   out_priority_o
);
  import prqs_pkg::*;

  res_t              slot_q [RES_DEPTH];
  logic [RPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RCNT_W-1:0] count_q, count_d;
  logic              pop_ok;
  res_t              head;

  assign empty       = (count_q == '0);
  assign res_space_o = (count_q != RCNT_W'(RES_DEPTH));
  assign pop_ok      = pop && !empty;
  assign head        = slot_q[rd_ptr_q];

  assign status_o       = head.status;
  assign out_task_id_o  = head.task_id;
  assign out_priority_o = head.prio;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (res_push_i) begin
      wr_ptr_d = (wr_ptr_q == RPTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + RPTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == RPTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + RPTR_W'(1);
    end
    if (res_push_i && !pop_ok) begin
      count_d = count_q + RCNT_W'(1);
    end else if (pop_ok && !res_push_i) begin
      count_d = count_q - RCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prqs_checker.sv =====
`default_nettype none

module prqs_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           push,
  input wire                           full,
  input wire                           empty,
  input wire                           pop,
  input wire [prqs_pkg::STATUS_W-1:0]  status_o,
  input wire [prqs_pkg::ID_W-1:0]      out_task_id_o,
  input wire [prqs_pkg::PRIO_W-1:0]    out_priority_o
);
  import prqs_pkg::*;

  // Right after reset the request queue is not full and the result queue is empty.
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !full && empty)
    else $error("queues not empty after reset");

  // Only a successful consume or peek names a task.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (out_task_id_o == '0 && out_priority_o == '0))
    else $error("refused or empty result carries a task");

  // The request queue fills only through an accepted word.
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted request");

  // The result queue drains only through a pop.
  a_empty_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result vanished without a pop");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(out_task_id_o)
                          && $stable(out_priority_o)))
    else $error("waiting result changed");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import prqs_pkg::*;

  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  // Mirror of the per-level ready queues and the list of results still owed.
  class ready_queue_scoreboard;
    logic [ID_W-1:0]       slot_id [NUM_LEVELS][QUEUE_DEPTH];
    int                    head_of [NUM_LEVELS];
    int                    tail_of [NUM_LEVELS];
    int                    count_of[NUM_LEVELS];
    logic [NUM_LEVELS-1:0] active;
    logic [MAX_TASKS-1:0]  is_ready;
    res_t                  due[$];
    int                    errors;

    function new();
      foreach (head_of[i]) begin
        head_of[i]  = 0;
        tail_of[i]  = 0;
        count_of[i] = 0;
      end
      active   = '0;
      is_ready = '0;
      errors   = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(op_e op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] lvl);
      res_t r;
      int   lv;
      r.status  = ST_EMPTY;
      r.task_id = '0;
      r.prio    = '0;
      case (op)
        OP_ADD: begin
          // A marked task is refused before the fullness of its level is looked at.
          if (int'(lvl) >= NUM_LEVELS || int'(id) >= MAX_TASKS) begin
            r.status = ST_FULL;
          end else if (is_ready[id]) begin
            r.status = ST_READY;
          end else if (count_of[lvl] >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot_id[lvl][tail_of[lvl]] = id;
            tail_of[lvl] = (tail_of[lvl] + 1) % QUEUE_DEPTH;
            count_of[lvl]++;
            active[lvl]  = 1'b1;
            is_ready[id] = 1'b1;
            r.status     = ST_OK;
          end
        end
        OP_CONSUME, OP_PEEK: begin
          lv = -1;
          for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (active[i]) lv = i;
          end
          if (lv >= 0) begin
            r.status  = ST_OK;
            r.task_id = slot_id[lv][head_of[lv]];
            r.prio    = PRIO_W'(lv);
            if (op == OP_CONSUME) begin
              head_of[lv] = (head_of[lv] + 1) % QUEUE_DEPTH;
              count_of[lv]--;
              if (count_of[lv] == 0) active[lv] = 1'b0;
              is_ready[r.task_id] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] lvl);
      res_t r;
      if (due.size() == 0) begin
        $error("unexpected word: status %0d, out_task_id %0d, out_priority %0d",
               status, id, lvl);
        errors++;
      end else begin
        r = due.pop_front();
        if (status !== r.status) begin
          $error("status: expected %0d, actual %0d", r.status, status);
          errors++;
        end
        if (id !== r.task_id) begin
          $error("out_task_id: expected %0d, actual %0d", r.task_id, id);
          errors++;
        end
        if (lvl !== r.prio) begin
          $error("out_priority: expected %0d, actual %0d", r.prio, lvl);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                push            = 1'b0;
  logic                full;
  logic [OP_W-1:0]     op_i            = '0;
  logic [ID_W-1:0]     task_id_i       = '0;
  logic [PRIO_W-1:0]   task_priority_i = '0;
  logic                empty;
  logic                pop             = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     out_task_id_o;
  logic [PRIO_W-1:0]   out_priority_o;

  ready_queue_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   words_sent    = 0;
  int   quiet_cycles  = 0;
  logic hold_off_req  = 1'b0;

  priority_ready_queue_scheduler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .out_task_id_o  (out_task_id_o),
    .out_priority_o (out_priority_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Outputs change only through the block's flops, so values read at the edge
  // are the ones that the edge samples.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_request(op_e'(op_i), task_id_i, task_priority_i);
      if (pop && !empty) sb.check_result(status_o, out_task_id_o, out_priority_o);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input op_e op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    op_i            <= op;
    task_id_i       <= id;
    task_priority_i <= lvl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (op != OP_NONE) words_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PRIO_W-1:0] pick_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return PRIO_W'($urandom_range(NUM_LEVELS - 1));
    endcase
  endfunction

  task automatic send_noise(input int n);
    repeat (n) begin
      send_word(op_e'($urandom_range(3)), ID_W'($urandom_range(63)),
                PRIO_W'($urandom_range(31)));
    end
  endtask

  // Adds spread over a few levels, the odd peek, then enough consumes to
  // empty what was added and sometimes one more.
  task automatic send_burst();
    logic [PRIO_W-1:0] lvls[3];
    int                n;
    int                nlev;
    foreach (lvls[i]) lvls[i] = pick_level();
    nlev = $urandom_range(1, 3);
    n    = $urandom_range(1, 8);
    repeat (n) begin
      send_word(OP_ADD, ID_W'($urandom_range(63)), lvls[$urandom_range(nlev - 1)]);
      if ($urandom_range(3) == 0) send_word(OP_PEEK, ID_W'($urandom), PRIO_W'($urandom));
    end
    repeat (n + $urandom_range(1)) begin
      if ($urandom_range(4) == 0) send_word(OP_PEEK, ID_W'($urandom), PRIO_W'($urandom));
      send_word(OP_CONSUME, ID_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  // Distinct tasks into one level up to its depth and sometimes past it, then take them back out.
  task automatic send_fill();
    logic [PRIO_W-1:0] lvl;
    int                base;
    int                k;
    lvl  = pick_level();
    base = $urandom_range(63);
    k    = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 4);
    for (int i = 0; i < k; i++) send_word(OP_ADD, ID_W'(base + i), lvl);
    send_word(OP_PEEK, '0, '0);
    repeat (k) send_word(OP_CONSUME, ID_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int target,
                           input bit hold_off);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (hold_off) hold_off_req = 1'b1;
    while (words_sent < target) begin
      case ($urandom_range(9))
        0, 1:    send_noise($urandom_range(2, 6));
        2:       send_fill();
        default: send_burst();
      endcase
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing ready yet, the unused op, the extreme ids and levels, ordering
    // between levels, and a repeated add of a waiting task.
    send_word(OP_CONSUME, '1, '1);
    send_word(OP_PEEK, '1, '1);
    send_word(OP_NONE, '1, '1);
    send_word(OP_ADD, '1, '1);
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, '1, '0);
    send_word(OP_PEEK, '0, '0);
    send_word(OP_CONSUME, '0, '0);
    send_word(OP_CONSUME, '0, '0);
    send_word(OP_CONSUME, '0, '0);
    // Fill the least urgent level, overflow it, then retry a waiting task there.
    for (int i = 0; i < QUEUE_DEPTH; i++) send_word(OP_ADD, ID_W'(i), '1);
    send_word(OP_ADD, ID_W'(QUEUE_DEPTH), '1);
    send_word(OP_ADD, ID_W'(5), '1);
    drain_results();

    run_phase(10, 70, 510, 1'b0);
    run_phase(70, 10, 980, 1'b0);
    run_phase(0, 0, 1450, 1'b1);

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
